// ----- src/gfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gfsc_pkg - shared types and constants
// Command and register codes, step size function, saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package gfsc_pkg;

    localparam int CMD_W    = 2;
    localparam int RATE_W   = 16;
    localparam int ANGLE_W  = 32;
    localparam int PERIOD_W = 7;
    localparam int STEP_W   = 12;
    localparam int BAND_W   = 16;
    localparam int CNT_W    = 4;
    localparam int CFG_W    = 4;
    localparam int IDX_W    = 2;

    localparam logic [CMD_W-1:0] CMD_GYRO = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CTRL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd3;

    localparam logic [IDX_W-1:0] REG_MICROSTEP_SHIFT = 2'd0;
    localparam logic [IDX_W-1:0] REG_DEADBAND_STEPS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_STALL_LIMIT     = 2'd2;

    localparam logic [PERIOD_W-1:0] SLOW_PERIOD = 7'd100;
    localparam logic [PERIOD_W-1:0] MID_PERIOD  = 7'd50;
    localparam logic [PERIOD_W-1:0] FAST_PERIOD = 7'd34;

    localparam logic [STEP_W-1:0] FULL_STEP_UNITS = 12'd2880;
    localparam logic [CNT_W-1:0]  STALL_MAX       = 4'd15;

    localparam logic [2:0]       RST_MICROSTEP_SHIFT = 3'd0;
    localparam logic [CNT_W-1:0] RST_DEADBAND_STEPS  = 4'd5;
    localparam logic [CNT_W-1:0] RST_STALL_LIMIT     = 4'd10;

    typedef struct packed {
        logic [2:0]       microstep_shift;
        logic [CNT_W-1:0] deadband_steps;
        logic [CNT_W-1:0] stall_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] target_angle_out;
        logic                      reset_request;
        logic                      running;
        logic [PERIOD_W-1:0]       step_period;
        logic                      direction_negative;
        logic                      step_level;
    } res_t;

    function automatic logic [STEP_W-1:0] step_units(input logic [2:0] shift);
        return FULL_STEP_UNITS >> shift;
    endfunction

    // clamp a 34-bit sum back into the signed 32-bit range
    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [ANGLE_W+1:0] v);
        logic signed [ANGLE_W-1:0] r;
        if ((v[ANGLE_W+1:ANGLE_W-1] == 3'b000) || (v[ANGLE_W+1:ANGLE_W-1] == 3'b111)) begin
            r = v[ANGLE_W-1:0];
        end else if (v[ANGLE_W+1]) begin
            r = {1'b1, {(ANGLE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/gfsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gfsc_cfg_regs - configuration register file
// Write-only registers for microstep shift, dead band and stall limit.
// ----------------------------------------------------------------------------
`default_nettype none

module gfsc_cfg_regs
    import gfsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MICROSTEP_SHIFT: cfg_next.microstep_shift = cfg_wdata[2:0];
                REG_DEADBAND_STEPS:  cfg_next.deadband_steps  = cfg_wdata;
                REG_STALL_LIMIT:     cfg_next.stall_limit     = cfg_wdata;
                default:             cfg_next = cfg_reg;   // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.microstep_shift <= RST_MICROSTEP_SHIFT;
            cfg_reg.deadband_steps  <= RST_DEADBAND_STEPS;
            cfg_reg.stall_limit     <= RST_STALL_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/gfsc_core.sv -----
// ----------------------------------------------------------------------------
// gfsc_core - controller state and per-command update
// Holds angles, stall counter and pin state; computes one word's result.
// ----------------------------------------------------------------------------
`default_nettype none

module gfsc_core
    import gfsc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic [CMD_W-1:0]          command,
    input  wire logic signed [RATE_W-1:0]  gyro_rate,
    input  wire logic signed [ANGLE_W-1:0] angle_value,
    input  wire cfg_t                      cfg,
    output res_t                           res
);

    logic signed [ANGLE_W-1:0] target_reg, target_next;
    logic signed [ANGLE_W-1:0] motor_reg, motor_next;
    logic signed [RATE_W-1:0]  last_rate_reg, last_rate_next;
    logic [CNT_W-1:0]          stall_cnt_reg, stall_cnt_next;
    logic                      pulse_reg, pulse_next;
    logic                      dir_reg, dir_next;
    logic                      run_reg, run_next;
    logic [PERIOD_W-1:0]       period_reg, period_next;
    logic                      request;

    logic [CNT_W-1:0]          cnt_inc;
    logic [STEP_W-1:0]         step_sz;
    logic [STEP_W:0]           step2;
    logic [STEP_W+1:0]         step3;
    logic [BAND_W-1:0]         band;
    logic signed [ANGLE_W+1:0] err;
    logic signed [ANGLE_W+1:0] abs_err34;
    logic [ANGLE_W:0]          abs_err;
    logic                      moving;
    logic signed [ANGLE_W+1:0] target_sum;
    logic signed [ANGLE_W+1:0] motor_sum;

    always_comb begin
        step_sz   = step_units(cfg.microstep_shift);
        step2     = {step_sz, 1'b0};
        step3     = {1'b0, step2} + {2'b00, step_sz};
        band      = BAND_W'(step_sz) * BAND_W'(cfg.deadband_steps);

        err       = {{2{target_reg[ANGLE_W-1]}}, target_reg}
                  - {{2{motor_reg[ANGLE_W-1]}}, motor_reg};
        abs_err34 = err[ANGLE_W+1] ? -err : err;
        abs_err   = abs_err34[ANGLE_W:0];
        // inside the dead band or under one step: no motion
        moving    = (abs_err >= (ANGLE_W+1)'(band)) && (abs_err >= (ANGLE_W+1)'(step_sz));

        target_sum = {{2{target_reg[ANGLE_W-1]}}, target_reg}
                   + (ANGLE_W+2)'(last_rate_reg) + (ANGLE_W+2)'(gyro_rate);
        motor_sum  = dir_reg
                   ? {{2{motor_reg[ANGLE_W-1]}}, motor_reg} - (ANGLE_W+2)'(step_sz)
                   : {{2{motor_reg[ANGLE_W-1]}}, motor_reg} + (ANGLE_W+2)'(step_sz);

        cnt_inc = (stall_cnt_reg < STALL_MAX) ? stall_cnt_reg + 1'b1 : stall_cnt_reg;

        target_next    = target_reg;
        motor_next     = motor_reg;
        last_rate_next = last_rate_reg;
        stall_cnt_next = stall_cnt_reg;
        pulse_next     = pulse_reg;
        dir_next       = dir_reg;
        run_next       = run_reg;
        period_next    = period_reg;
        request        = 1'b0;

        unique case (command)
            CMD_GYRO: begin
                stall_cnt_next = (gyro_rate == last_rate_reg) ? cnt_inc : '0;
                if ((stall_cnt_next == cfg.stall_limit) && (cfg.stall_limit != '0)) begin
                    request        = 1'b1;
                    stall_cnt_next = '0;
                end
                target_next    = sat32(target_sum);
                last_rate_next = gyro_rate;
            end
            CMD_CTRL: begin
                if (moving) begin
                    dir_next = err[ANGLE_W+1];
                    run_next = 1'b1;
                    priority if (abs_err >= (ANGLE_W+1)'(step3)) begin
                        period_next = FAST_PERIOD;
                    end else if (abs_err >= (ANGLE_W+1)'(step2)) begin
                        period_next = MID_PERIOD;
                    end else begin
                        period_next = SLOW_PERIOD;
                    end
                end else begin
                    run_next    = 1'b0;
                    period_next = SLOW_PERIOD;
                end
            end
            CMD_STEP: begin
                if (run_reg) begin
                    pulse_next = !pulse_reg;
                    // motor advances on the falling edge of the pin
                    if (pulse_reg) begin
                        motor_next = sat32(motor_sum);
                    end
                end
            end
            CMD_SET: begin
                motor_next = angle_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= '0;
            motor_reg     <= '0;
            last_rate_reg <= '0;
            stall_cnt_reg <= '0;
            pulse_reg     <= 1'b0;
            dir_reg       <= 1'b0;
            run_reg       <= 1'b0;
            period_reg    <= SLOW_PERIOD;
        end else if (en) begin
            target_reg    <= target_next;
            motor_reg     <= motor_next;
            last_rate_reg <= last_rate_next;
            stall_cnt_reg <= stall_cnt_next;
            pulse_reg     <= pulse_next;
            dir_reg       <= dir_next;
            run_reg       <= run_next;
            period_reg    <= period_next;
        end
    end

    always_comb begin
        res.step_level         = pulse_next;
        res.direction_negative = dir_next;
        res.step_period        = period_next;
        res.running            = run_next;
        res.reset_request      = request;
        res.target_angle_out   = target_next;
    end

endmodule

`default_nettype wire

// ----- src/gyro_follow_stepper_controller.sv -----
// ----------------------------------------------------------------------------
// gyro_follow_stepper_controller - gyro-following stepper motor controller
// Integrates gyro rate into a target angle and drives step/direction pins.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word per event. s_tuser carries the command
// (gyro sample, control tick, step tick, set motor angle), s_tdata the
// gyro rate and the angle value. Every accepted word produces exactly one
// result word on m_* with the pin levels, step period, run flag, reset
// request and the integrated target angle.
// Path: an accepted word waits in the input register; its result is
// registered in the output register and shown on m_*. Throughput: one
// word per cycle while m_tready is high; each word's update is one pass
// through one 34-bit add/compare stage between input and output registers.
// Backpressure: when m_tready is low the output word holds and the input
// register still takes one more word; s_tready then drops until the
// output drains.
// Reset (aresetn low, synchronous): both registers empty, angles and
// stall counter zero, pins low, period 100, registers to their defaults.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_follow_stepper_controller
    import gfsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // config port
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    // input stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [47:0]      s_tdata,   // [15:0] gyro_rate, [47:16] angle_value
    input  wire logic [CMD_W-1:0] s_tuser,   // [1:0] command
    // result stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [0] step_level, [1] direction_negative, [8:2] step_period, [9] running,
    // [10] reset_request, [42:11] target_angle_out, [47:43] zero
    output logic [47:0]           m_tdata
);

    cfg_t cfg;

    logic                      in_valid_reg, in_valid_next;
    logic [CMD_W-1:0]          in_cmd_reg;
    logic signed [RATE_W-1:0]  in_rate_reg;
    logic signed [ANGLE_W-1:0] in_angle_reg;
    logic                      out_valid_reg, out_valid_next;
    res_t                      out_res_reg;
    res_t                      core_res;
    logic                      advance;
    logic                      fire;

    gfsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = advance || !in_valid_reg;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tuser;
            in_rate_reg  <= s_tdata[RATE_W-1:0];
            in_angle_reg <= s_tdata[RATE_W+ANGLE_W-1:RATE_W];
        end
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    gfsc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (fire),
        .command     (in_cmd_reg),
        .gyro_rate   (in_rate_reg),
        .angle_value (in_angle_reg),
        .cfg         (cfg),
        .res         (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_res_reg.target_angle_out,
                       out_res_reg.reset_request,
                       out_res_reg.running,
                       out_res_reg.step_period,
                       out_res_reg.direction_negative,
                       out_res_reg.step_level};

    // an empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("s_tready low with empty input register");

    // a stalled word in the input register is not lost and its command and angle stay unchanged
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_cmd_reg)
                                     && $stable(in_angle_reg))
        else $error("stalled input word changed");

    // only the three legal half-periods ever leave the block
    a_period_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_res_reg.step_period == SLOW_PERIOD)
                       || (out_res_reg.step_period == MID_PERIOD)
                       || (out_res_reg.step_period == FAST_PERIOD))
        else $error("illegal step period");

    // a stopped motor always reports the slow period
    a_stopped_slow: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_res_reg.running |-> out_res_reg.step_period == SLOW_PERIOD)
        else $error("stopped motor with fast period");

endmodule

`default_nettype wire
